@@ hw/rtl/tslk_pkg.sv @@
// ----------------------------------------------------------------------------
// tslk_pkg
// shared types and constants for the ts sync lock and byte position block
// ----------------------------------------------------------------------------
package tslk_pkg;

	// sync byte of a transport packet
	localparam logic [7:0] SYNC_MARK = 8'h47;

	// configuration register reset values
	localparam logic [7:0] PKT_LEN_RST  = 8'd188;
	localparam logic [3:0] LOCK_THR_RST = 4'd5;

	// configuration port geometry
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LENGTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCK_THRESHOLD = 1'd1;

	// per-packet decision flags from the lock tracker
	typedef struct packed {
		logic packet_valid;
		logic sync_loss_event;
		logic sync_byte_error_event;
	} lock_flags_t;

	// lock tracker state, exported for checking
	typedef struct packed {
		logic       locked;
		logic       loss_pending;
		logic [3:0] good_count;
	} lock_status_t;

	// one result request
	typedef struct packed {
		lock_flags_t flags;
		logic [31:0] byte_position;
		logic        carry_flag;
	} result_t;

endpackage

@@ hw/rtl/tslk_if.sv @@
// ----------------------------------------------------------------------------
// tslk_if
// valid/ready channels for packet requests and result requests
// ----------------------------------------------------------------------------
interface tslk_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_byte;

	modport source (output valid, output first_byte, input ready);
	modport sink (input valid, input first_byte, output ready);
endinterface

interface tslk_out_if;
	logic        valid;
	logic        ready;
	logic        packet_valid;
	logic        sync_loss_event;
	logic        sync_byte_error_event;
	logic [31:0] byte_position;
	logic        carry_flag;

	modport source (
		output valid, output packet_valid, output sync_loss_event,
		output sync_byte_error_event, output byte_position, output carry_flag,
		input ready
	);
	modport sink (
		input valid, input packet_valid, input sync_loss_event,
		input sync_byte_error_event, input byte_position, input carry_flag,
		output ready
	);
endinterface

@@ hw/rtl/ts_sync_lock_and_byte_position.sv @@
// ----------------------------------------------------------------------------
// ts_sync_lock_and_byte_position
// transport stream sync byte lock and running byte position
// ----------------------------------------------------------------------------
//
//  channel | direction | payload
//  --------+-----------+----------------------------------------------------
//  pkt     | in        | first_byte
//  res     | out       | packet_valid, sync_loss_event, sync_byte_error_event,
//          |           | byte_position, carry_flag
//  cfg     | in        | cfg_we, cfg_index, cfg_data (write only)
//
//  one packet request per cycle sustained while the receiver takes results;
//  each result passes through the input register, then the result register
//  lock state and position update in the single step from s1 to s2
//  a new packet is taken while a finished result waits in s2, as long as
//  s1 is empty or moving on
//  asynchronous active-low reset clears valids, lock state, position and
//  the config registers (length 188, threshold 5)
//
module ts_sync_lock_and_byte_position (
	input  logic                             clk,
	input  logic                             arst_n,
	tslk_in_if.sink                          pkt,
	tslk_out_if.source                       res,
	input  logic                             cfg_we,
	input  logic [tslk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tslk_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// configuration registers
	logic [7:0] pkt_len_q;
	logic [3:0] lock_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_len_q  <= tslk_pkg::PKT_LEN_RST;
			lock_thr_q <= tslk_pkg::LOCK_THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tslk_pkg::CFG_PACKET_LENGTH: begin
					pkt_len_q <= cfg_data[7:0];
				end
				tslk_pkg::CFG_LOCK_THRESHOLD: begin
					lock_thr_q <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline control
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       v_s2;
	logic       advance;

	tslk_pkg::result_t      result_s2;
	tslk_pkg::lock_flags_t  flags;
	tslk_pkg::lock_status_t status;
	logic [31:0]            next_position;
	logic                   carry;

	// s1 moves to s2 when the result register is free or being drained
	assign advance   = v_s1 && (!v_s2 || res.ready);
	assign pkt.ready = !v_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pkt.ready) begin
			v_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			byte_s1 <= pkt.first_byte;
		end
	end

	// per-packet decision, state advances only when the request moves on
	tslk_lock u_lock (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.first_byte     (byte_s1),
		.lock_threshold (lock_thr_q),
		.flags          (flags),
		.status         (status)
	);

	tslk_pos u_pos (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.packet_length (pkt_len_q),
		.next_position (next_position),
		.carry         (carry)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || res.ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.flags         <= flags;
			result_s2.byte_position <= next_position;
			result_s2.carry_flag    <= carry;
		end
	end

	assign res.valid                 = v_s2;
	assign res.packet_valid          = result_s2.flags.packet_valid;
	assign res.sync_loss_event       = result_s2.flags.sync_loss_event;
	assign res.sync_byte_error_event = result_s2.flags.sync_byte_error_event;
	assign res.byte_position         = result_s2.byte_position;
	assign res.carry_flag            = result_s2.carry_flag;

	// at most one of the three flags per packet
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> $onehot0({res.packet_valid, res.sync_loss_event,
			res.sync_byte_error_event}))
		else $error("more than one packet flag set");

	// a wrapped position never passes the packet length
	a_wrap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.carry_flag) |-> (res.byte_position <= {24'd0, pkt_len_q}))
		else $error("wrapped byte position out of range");

	// regaining lock clears a pending loss
	a_lock_loss: assert property (@(posedge clk) disable iff (!arst_n)
		status.locked |-> (!status.loss_pending && status.good_count == 4'd0))
		else $error("locked with loss pending or nonzero count");

	// a request waiting in s1 with s2 free moves on at the next edge
	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !v_s2) |=> v_s2)
		else $error("input register did not move to result register");

endmodule

@@ hw/rtl/tslk_pos.sv @@
// ----------------------------------------------------------------------------
// tslk_pos
// running 32-bit byte position, advanced by the packet length per packet
// ----------------------------------------------------------------------------
module tslk_pos (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  packet_length,
	output logic [31:0] next_position,
	output logic        carry
);

	logic [31:0] position_q;
	logic [32:0] sum;

	// on wrap the position lands one past a plain modulo wrap
	assign sum           = {1'b0, position_q} + {25'd0, packet_length};
	assign carry         = sum[32];
	assign next_position = sum[31:0] + {31'd0, carry};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
		end else if (step) begin
			position_q <= next_position;
		end
	end

endmodule

@@ hw/rtl/tslk_lock.sv @@
// ----------------------------------------------------------------------------
// tslk_lock
// sync byte lock tracker with loss and sync byte error events
// ----------------------------------------------------------------------------
module tslk_lock (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             first_byte,
	input  logic [3:0]             lock_threshold,
	output tslk_pkg::lock_flags_t  flags,
	output tslk_pkg::lock_status_t status
);

	logic       locked_q;
	logic       loss_pending_q;
	logic [3:0] good_count_q;

	logic       locked_d;
	logic       loss_pending_d;
	logic [3:0] good_count_d;
	logic [3:0] count_inc;
	logic       is_sync;

	assign is_sync   = (first_byte == tslk_pkg::SYNC_MARK);
	assign count_inc = good_count_q + 4'd1;

	always_comb begin
		locked_d       = locked_q;
		loss_pending_d = loss_pending_q;
		good_count_d   = good_count_q;
		flags          = '0;
		if (!locked_q) begin
			if (is_sync) begin
				if (count_inc >= lock_threshold) begin
					locked_d                    = 1'b1;
					good_count_d                = '0;
					flags.sync_loss_event       = loss_pending_q;
					loss_pending_d              = 1'b0;
				end else begin
					good_count_d = count_inc;
				end
			end else begin
				flags.sync_byte_error_event = loss_pending_q;
				good_count_d                = '0;
			end
		end else begin
			if (is_sync) begin
				flags.packet_valid = 1'b1;
			end else begin
				// drop lock, no event for this packet
				loss_pending_d = 1'b1;
				locked_d       = 1'b0;
				good_count_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q       <= 1'b0;
			loss_pending_q <= 1'b0;
			good_count_q   <= '0;
		end else if (step) begin
			locked_q       <= locked_d;
			loss_pending_q <= loss_pending_d;
			good_count_q   <= good_count_d;
		end
	end

	assign status.locked       = locked_q;
	assign status.loss_pending = loss_pending_q;
	assign status.good_count   = good_count_q;

endmodule

@@ tb/sv/tb_ts_sync_lock_and_byte_position.sv @@
// ----------------------------------------------------------------------------
// tb_ts_sync_lock_and_byte_position
// self-checking bench for the ts sync lock and byte position block
//
// packet requests go in on one valid/ready channel and result requests come
// out on another. a behavioral tracker of the lock state and byte position
// predicts every result at the moment its packet is accepted. the checker
// compares each result with the oldest prediction. directed packets cover
// lock, loss, relock and the threshold extremes. random streams run under
// several register settings, with random idling on both sides, a long
// receiver hold-off and a stretch with no idling at all.
// ----------------------------------------------------------------------------
module tb_ts_sync_lock_and_byte_position;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [tslk_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tslk_pkg::CFG_DATA_W-1:0] cfg_data;

	tslk_in_if pkt_ch ();
	tslk_out_if res_ch ();

	ts_sync_lock_and_byte_position dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns period
	always #6ns clk = ~clk;

	// tracker copy of the block's registers
	logic [7:0] cur_pkt_len;
	logic [3:0] cur_lock_thr;

	// tracker copy of the lock state and running position
	logic        trk_locked;
	logic [3:0]  trk_good_cnt;
	logic        trk_loss_pending;
	logic [31:0] trk_position;

	// predicted results, oldest first
	tslk_pkg::result_t awaited_results[$];
	tslk_pkg::result_t seen_result;
	tslk_pkg::result_t want_result;
	int      mismatch_count = 0;

	// idling controls shared by the sender, the receiver and the tests
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_hold_req = 0;

	// one packet through the tracker: position first, then the lock decision
	// note: a wrap needs about 2^32 / length packets, far beyond this run, so
	// the carry is only ever predicted low here
	function automatic tslk_pkg::result_t track_packet(input logic [7:0] first_byte);
		tslk_pkg::result_t r;
		logic [32:0] sum;
		logic [3:0]  next_cnt;
		r = '0;
		sum = {1'b0, trk_position} + {25'd0, cur_pkt_len};
		if (sum[32]) begin
			// wrap lands one past a plain modulo wrap
			r.carry_flag = 1'b1;
			trk_position = {24'd0, cur_pkt_len} - (32'hFFFF_FFFF - trk_position);
		end else begin
			trk_position = sum[31:0];
		end
		r.byte_position = trk_position;

		if (!trk_locked) begin
			if (first_byte == tslk_pkg::SYNC_MARK) begin
				next_cnt = trk_good_cnt + 4'd1;
				// threshold zero behaves as one since any count passes
				if (next_cnt >= cur_lock_thr) begin
					trk_locked = 1'b1;
					trk_good_cnt = 4'd0;
					if (trk_loss_pending) begin
						r.flags.sync_loss_event = 1'b1;
						trk_loss_pending = 1'b0;
					end
				end else begin
					trk_good_cnt = next_cnt;
				end
			end else begin
				r.flags.sync_byte_error_event = trk_loss_pending;
				trk_good_cnt = 4'd0;
			end
		end else begin
			if (first_byte == tslk_pkg::SYNC_MARK) begin
				r.flags.packet_valid = 1'b1;
			end else begin
				// drop lock quietly, the event comes on relock
				trk_loss_pending = 1'b1;
				trk_locked = 1'b0;
				trk_good_cnt = 4'd0;
			end
		end
		return r;
	endfunction

	// any byte but the sync byte, often a single bit away from it
	function automatic logic [7:0] pick_miss();
		logic [7:0] b;
		if ($urandom_range(3) == 0) begin
			b = tslk_pkg::SYNC_MARK ^ (8'h01 << $urandom_range(7));
		end else begin
			do b = 8'($urandom_range(255)); while (b == tslk_pkg::SYNC_MARK);
		end
		return b;
	endfunction

	// offer one packet request, with random idle cycles ahead of it, and
	// record its prediction at the edge where it is accepted
	// valid stays high on return so back-to-back requests need no toggle
	task automatic send_packet(input logic [7:0] first_byte);
		while (!tx_steady && $urandom_range(99) < 38) begin
			pkt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pkt_ch.valid <= 1'b1;
		pkt_ch.first_byte <= first_byte;
		do @(posedge clk); while (!pkt_ch.ready);
		awaited_results.push_back(track_packet(first_byte));
	endtask

	// stop offering and let every outstanding result come out, then let the
	// two-stage pipe settle
	task automatic drain_block();
		pkt_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// write both registers while the block is idle
	// thr_data may carry upper bits, only the low nibble counts
	task automatic set_config(input logic [7:0] len_data, input logic [7:0] thr_data);
		drain_block();
		cfg_we <= 1'b1;
		cfg_index <= tslk_pkg::CFG_PACKET_LENGTH;
		cfg_data <= len_data;
		@(posedge clk);
		cur_pkt_len = len_data;
		cfg_index <= tslk_pkg::CFG_LOCK_THRESHOLD;
		cfg_data <= thr_data;
		@(posedge clk);
		cur_lock_thr = thr_data[3:0];
		cfg_we <= 1'b0;
	endtask

	// random traffic: mostly sync runs, up to ten longer than the threshold and
	// each ended by a miss, plus stray bytes and runs broken off before lock
	task automatic send_stream(input int n);
		int sent;
		int run;
		int kind;
		int thr_eff;
		sent = 0;
		while (sent < n) begin
			kind = $urandom_range(99);
			thr_eff = (cur_lock_thr == 4'd0) ? 1 : int'(cur_lock_thr);
			if (kind < 75)
				run = $urandom_range(thr_eff + 10, 1);
			else if (kind < 90)
				run = 0;
			else
				run = $urandom_range(thr_eff - 1, 0);
			repeat (run) send_packet(tslk_pkg::SYNC_MARK);
			sent += run;
			if (kind >= 75 && kind < 90)
				send_packet(8'($urandom_range(255)));
			else
				send_packet(pick_miss());
			sent++;
		end
	endtask

	// lock at the reset threshold, loss while locked, sync byte errors while
	// the loss is pending, a miss with no loss pending, and a broken run
	task automatic test_lock_and_loss();
		send_packet(8'hFF);
		repeat (4) send_packet(tslk_pkg::SYNC_MARK);
		send_packet(tslk_pkg::SYNC_MARK);
		send_packet(tslk_pkg::SYNC_MARK);
		send_packet(8'h00);
		send_packet(8'hFF);
		repeat (2) send_packet(tslk_pkg::SYNC_MARK);
		send_packet(tslk_pkg::SYNC_MARK ^ 8'h01);
		send_packet(tslk_pkg::SYNC_MARK ^ 8'h0F);
	endtask

	// zero length with zero threshold relocks on one sync byte each time,
	// then the longest length with the highest threshold
	task automatic test_threshold_extremes();
		set_config(8'd0, 8'd0);
		send_packet(tslk_pkg::SYNC_MARK);
		send_packet(tslk_pkg::SYNC_MARK);
		send_packet(8'h48);
		send_packet(tslk_pkg::SYNC_MARK);
		set_config(8'd255, 8'd15);
		send_packet(8'h80);
		repeat (3) send_packet(tslk_pkg::SYNC_MARK);
		send_packet(8'h08);
	endtask

	// random streams under several register settings
	task automatic test_random_settings();
		logic [7:0] len_tab [6];
		logic [7:0] thr_tab [6];
		len_tab = '{8'd188, 8'd204, 8'd0, 8'd255, 8'd1, 8'd188};
		thr_tab = '{8'd5, 8'd1, 8'd15, 8'd0, 8'hA7, 8'd2};
		for (int i = 0; i < 6; i++) begin
			set_config(len_tab[i], thr_tab[i]);
			send_stream(130);
		end
		set_config(8'($urandom_range(255)), 8'($urandom_range(255)));
		send_stream(120);
	endtask

	// receiver holds off for a long stretch while the sender keeps pushing,
	// so the pipe fills and stalls the packet channel
	task automatic test_backpressure();
		set_config(8'd204, 8'd3);
		rx_hold_req = 40;
		tx_steady = 1'b1;
		send_stream(40);
		tx_steady = 1'b0;
	endtask

	// full rate on both sides
	task automatic test_steady_stream();
		set_config(8'd188, 8'd5);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		send_stream(100);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// receiver: random ready, with hold-offs counted here
	initial begin
		int hold_left;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left != 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else if (rx_steady) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= 38);
			end
		end
	end

	// result checker: sampled at the edge, compared with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen_result.flags.packet_valid = res_ch.packet_valid;
			seen_result.flags.sync_loss_event = res_ch.sync_loss_event;
			seen_result.flags.sync_byte_error_event = res_ch.sync_byte_error_event;
			seen_result.byte_position = res_ch.byte_position;
			seen_result.carry_flag = res_ch.carry_flag;
			if (awaited_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: result request with none awaited: %p", $realtime, seen_result);
				mismatch_count++;
			end else begin
				want_result = awaited_results.pop_front();
				if (seen_result.flags.packet_valid !== want_result.flags.packet_valid ||
					seen_result.flags.sync_loss_event !== want_result.flags.sync_loss_event ||
					seen_result.flags.sync_byte_error_event !==
						want_result.flags.sync_byte_error_event ||
					seen_result.byte_position !== want_result.byte_position ||
					seen_result.carry_flag !== want_result.carry_flag) begin
					if (mismatch_count < 10)
						$display("%0t: expected %p, got %p", $realtime, want_result, seen_result);
					mismatch_count++;
				end
			end
		end
	end

	// main sequence
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= tslk_pkg::CFG_PACKET_LENGTH;
		cfg_data <= '0;
		pkt_ch.valid <= 1'b0;
		pkt_ch.first_byte <= '0;
		cur_pkt_len = tslk_pkg::PKT_LEN_RST;
		cur_lock_thr = tslk_pkg::LOCK_THR_RST;
		trk_locked = 1'b0;
		trk_good_cnt = 4'd0;
		trk_loss_pending = 1'b0;
		trk_position = 32'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lock_and_loss();
		test_threshold_extremes();
		test_random_settings();
		test_backpressure();
		test_steady_stream();

		// wait out the last results, then keep watching for strays
		drain_block();
		repeat (10) @(posedge clk);
		mismatch_count += awaited_results.size();
		if (mismatch_count == 0)
			$display("ts_sync_lock_and_byte_position: match");
		else
			$display("ts_sync_lock_and_byte_position: mismatch");
		$finish;
	end

	// run limit: ends the run as a mismatch if the sequence hangs
	initial begin
		#5ms;
		$display("ts_sync_lock_and_byte_position: mismatch");
		$finish;
	end

endmodule
